// ===== rtl/ips_pkg.sv =====
package ips_pkg;

   // default dictionary geometry
   localparam int WORDS_DEF    = 16;
   localparam int WORD_LEN_DEF = 64;

   // fixed field widths of the channels
   localparam int CHAR_W  = 8;
   localparam int SLOT_W  = 4;
   localparam int CPOS_W  = 6;
   localparam int INDEX_W = 4;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 8;

   // typed character that restarts the search
   localparam logic [CHAR_W-1:0] RESET_CHAR = 8'd32;

   // item kinds carried in req_tuser
   localparam logic MODE_TYPE = 1'b0;
   localparam logic MODE_LOAD = 1'b1;

   // sequencer states
   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_EMIT
   } state_type;

endpackage

// ===== rtl/incremental_prefix_search.sv =====
// channel  dir  handshake              tdata / tuser / tlast
// req      in   req_tvalid/req_tready  char_code, word_slot, char_pos / mode / -
// rsp      out  rsp_tvalid/rsp_tready  word_index / - / last
//
// a load item or a restart character is taken in idle
// a typed character runs a compare sweep (one memory read per word through the
// single dictionary read port), then an emit sweep over the words up to the last
// live word, which output stalls hold off
// after reset the dictionary is cleared one byte a cycle, all 2**(clog2(WORDS) +
// clog2(WORD_LEN)) bytes (1024 at the defaults), with req_tready low
// a result waiting in the output register does not hold off the next item
module incremental_prefix_search
   import ips_pkg::*;
#(
   parameter int WORDS    = WORDS_DEF,
   parameter int WORD_LEN = WORD_LEN_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // char_code[7:0], word_slot[11:8], char_pos[17:12]
   input  logic                  req_tuser,  // mode
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // word_index[3:0]
   output logic                  rsp_tlast
);

   localparam int WB  = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int PB  = (WORD_LEN > 1) ? $clog2(WORD_LEN) : 1;
   localparam int AW  = WB + PB;
   localparam int SXW = (WB > SLOT_W) ? WB : SLOT_W;
   localparam int PXW = (PB > CPOS_W) ? PB : CPOS_W;
   localparam int IXW = (WB > INDEX_W) ? WB : INDEX_W;

   // input fields
   logic [CHAR_W-1:0] req_char;
   logic [SLOT_W-1:0] req_slot;
   logic [CPOS_W-1:0] req_cpos;
   logic [SXW-1:0]    slot_ext;
   logic [PXW-1:0]    cpos_ext;
   logic              req_fire;
   logic              load_ok;

   // state and registers
   state_type         state_ff, state_in;
   logic [AW-1:0]     clr_cnt_ff, clr_cnt_in;
   logic [WORDS-1:0]  live_ff, live_in;
   logic [PB:0]       pos_ff, pos_in;
   logic [CHAR_W-1:0] ch_ff, ch_in;
   logic [WB-1:0]     scan_cnt_ff, scan_cnt_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic [WB-1:0]     cmp_idx_ff, cmp_idx_in;
   logic [WB-1:0]     last_idx_ff, last_idx_in;
   logic              any_ff, any_in;
   logic [WB-1:0]     emit_cnt_ff, emit_cnt_in;
   logic              rsp_vld_ff, rsp_vld_in;
   logic [WB-1:0]     rsp_word_ff, rsp_word_in;
   logic              rsp_last_ff, rsp_last_in;

   // dictionary memory
   logic [CHAR_W-1:0] dict_mem [2**AW];
   logic [CHAR_W-1:0] rdata_ff;
   logic [AW-1:0]     raddr;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [CHAR_W-1:0] mem_wdata;

   // sequencer controls
   logic              slot_free;
   logic              clear_done;
   logic              scan_done;
   logic              emit_done;
   logic              start_scan;
   logic              restart;
   logic [IXW-1:0]    index_ext;

   assign req_char = req_tdata[7:0];
   assign req_slot = req_tdata[11:8];
   assign req_cpos = req_tdata[17:12];
   assign slot_ext = SXW'(req_slot);
   assign cpos_ext = PXW'(req_cpos);
   assign req_fire = req_tvalid && req_tready;
   assign load_ok  = (32'(req_slot) < WORDS) && (32'(req_cpos) < WORD_LEN);

   assign slot_free  = !rsp_vld_ff || rsp_tready;
   assign clear_done = (clr_cnt_ff == {AW{1'b1}});
   assign scan_done  = (scan_cnt_ff == WB'(WORDS - 1));
   assign emit_done  = !any_ff || (slot_free && (emit_cnt_ff == last_idx_ff));
   assign restart    = req_fire && (req_tuser == MODE_TYPE) && (req_char == RESET_CHAR);
   assign start_scan = req_fire && (req_tuser == MODE_TYPE) && (req_char != RESET_CHAR)
                       && (pos_ff < (PB + 1)'(WORD_LEN));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: if (clear_done) state_in = S_IDLE;
         S_IDLE:  if (start_scan) state_in = S_SCAN;
         S_SCAN:  if (scan_done) state_in = S_DRAIN;
         S_DRAIN: state_in = S_EMIT;
         S_EMIT:  if (emit_done) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // handshake and memory write controls
   always_comb begin
      req_tready = 1'b0;
      mem_we     = 1'b0;
      mem_waddr  = {slot_ext[WB-1:0], cpos_ext[PB-1:0]};
      mem_wdata  = req_char;
      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_ff;
            mem_wdata = '0;
         end
         S_IDLE: begin
            req_tready = 1'b1;
            mem_we     = req_fire && (req_tuser == MODE_LOAD) && load_ok;
         end
         S_SCAN, S_DRAIN, S_EMIT: begin
            req_tready = 1'b0;
         end
         default: req_tready = 1'b0;
      endcase
   end

   assign raddr = {scan_cnt_ff, pos_ff[PB-1:0]};

   // datapath next values
   always_comb begin
      clr_cnt_in  = clr_cnt_ff;
      live_in     = live_ff;
      pos_in      = pos_ff;
      ch_in       = ch_ff;
      scan_cnt_in = scan_cnt_ff;
      cmp_vld_in  = (state_ff == S_SCAN);
      cmp_idx_in  = scan_cnt_ff;
      last_idx_in = last_idx_ff;
      any_in      = any_ff;
      emit_cnt_in = emit_cnt_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_word_in = rsp_word_ff;
      rsp_last_in = rsp_last_ff;

      // clearing sweep
      if (state_ff == S_CLEAR) begin
         clr_cnt_in = clr_cnt_ff + AW'(1);
      end

      // restart and scan launch
      if (restart) begin
         live_in = '1;
         pos_in  = '0;
      end
      if (start_scan) begin
         ch_in       = req_char;
         scan_cnt_in = '0;
         any_in      = 1'b0;
         emit_cnt_in = '0;
      end

      // read issue
      if (state_ff == S_SCAN && !scan_done) begin
         scan_cnt_in = scan_cnt_ff + WB'(1);
      end

      // compare of the word read last cycle
      if (cmp_vld_ff && live_ff[cmp_idx_ff]) begin
         if (rdata_ff != ch_ff) begin
            live_in[cmp_idx_ff] = 1'b0;
         end else begin
            last_idx_in = cmp_idx_ff;
            any_in      = 1'b1;
         end
      end

      if (state_ff == S_DRAIN) begin
         pos_in = pos_ff + (PB + 1)'(1);
      end

      // emit sweep over the live words
      if (state_ff == S_EMIT && any_ff && slot_free) begin
         emit_cnt_in = emit_cnt_ff + WB'(1);
         if (live_ff[emit_cnt_ff]) begin
            rsp_vld_in  = 1'b1;
            rsp_word_in = emit_cnt_ff;
            rsp_last_in = (emit_cnt_ff == last_idx_ff);
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_cnt_ff <= '0;
         live_ff    <= '1;
         pos_ff     <= '0;
         cmp_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         any_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         live_ff    <= live_in;
         pos_ff     <= pos_in;
         cmp_vld_ff <= cmp_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         any_ff     <= any_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ch_ff       <= ch_in;
      scan_cnt_ff <= scan_cnt_in;
      cmp_idx_ff  <= cmp_idx_in;
      last_idx_ff <= last_idx_in;
      emit_cnt_ff <= emit_cnt_in;
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
   end

   // dictionary memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         dict_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= dict_mem[raddr];
   end

   // result channel
   assign index_ext  = IXW'(rsp_word_ff);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {(RSP_DATA_W - INDEX_W)'(0), index_ext[INDEX_W-1:0]};
   assign rsp_tlast  = rsp_last_ff;

   // a result only appears out of the emit sweep
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(state_ff == S_EMIT))
      else $error("result raised outside emit sweep");

   // no result and no req_tready while the dictionary is being cleared
   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !rsp_vld_ff && !req_tready)
      else $error("activity during clearing sweep");

   // words only come back to life through a restart in idle
   a_live_shrinks: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |=> (live_ff & ~$past(live_ff)) == '0)
      else $error("live word revived during search");

   // the typed position never passes the word length
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= (PB + 1)'(WORD_LEN))
      else $error("typed position out of range");

   // emitting the highest live word of the run flags the last result and returns to idle
   a_last_is_top: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && any_ff && slot_free && emit_cnt_ff == last_idx_ff)
      |=> rsp_vld_ff && rsp_last_ff && state_ff == S_IDLE)
      else $error("run ended without a last result");

endmodule

// ===== tb/incremental_prefix_search_tb.sv =====
`timescale 1ns / 1ps

module incremental_prefix_search_tb;
   import ips_pkg::*;

   localparam int TOTAL_ITEMS = 420;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 64;

   // tracks dictionary, live words and typed position, and queues the matches they imply
   class prefix_tracker;
      typedef struct packed {
         logic [INDEX_W-1:0] index;
         logic               last;
      } match_type;

      logic [CHAR_W-1:0]    dict_bytes [WORDS_DEF][WORD_LEN_DEF];
      logic [WORDS_DEF-1:0] live_words;
      logic [6:0]           type_pos;
      match_type            pending_matches [$];
      int                   failures;

      function new();
         foreach (dict_bytes[w, p]) dict_bytes[w][p] = '0;
         live_words = '1;
         type_pos = '0;
         failures = 0;
      endfunction

      // slot and position cannot leave the dictionary at these widths
      function void note_item(logic mode, logic [CHAR_W-1:0] ch, logic [SLOT_W-1:0] slot,
                              logic [CPOS_W-1:0] cpos);
         int top;
         top = -1;
         if (mode == MODE_LOAD) begin
            dict_bytes[slot][cpos] = ch;
         end else if (ch == RESET_CHAR) begin
            live_words = '1;
            type_pos = '0;
         end else if (type_pos < WORD_LEN_DEF) begin
            // narrow the live set, remember the highest survivor for the last flag
            for (int w = 0; w < WORDS_DEF; w++) begin
               if (live_words[w] && dict_bytes[w][type_pos] != ch) live_words[w] = 1'b0;
               if (live_words[w]) top = w;
            end
            for (int w = 0; w < WORDS_DEF; w++) begin
               if (live_words[w]) pending_matches.push_back('{INDEX_W'(w), w == top});
            end
            type_pos++;
         end
      endfunction

      function void check_match(logic [INDEX_W-1:0] index, logic last);
         match_type want;
         if (pending_matches.size() == 0) begin
            $display("%0t: unexpected item: expected none, got word_index %0d last %0b",
                     $time, index, last);
            failures++;
         end else begin
            want = pending_matches.pop_front();
            if (want.index !== index) begin
               $display("%0t: word_index mismatch: expected %0d, got %0d",
                        $time, want.index, index);
               failures++;
            end
            if (want.last !== last) begin
               $display("%0t: last mismatch: expected %0b, got %0b", $time, want.last, last);
               failures++;
            end
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;  // char_code[7:0], word_slot[11:8], char_pos[17:12]
   logic                  req_tuser;  // mode
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;  // word_index[3:0]
   logic                  rsp_tlast;

   prefix_tracker tracker;
   bit            idle_on;
   int            sent_items;
   int            cycle_count;

   incremental_prefix_search dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   // present one item, wait for the handshake, then book it
   task automatic send_item(logic mode, logic [CHAR_W-1:0] ch, logic [SLOT_W-1:0] slot,
                            logic [CPOS_W-1:0] cpos);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {6'b0, cpos, slot, ch};
      do @(posedge clock); while (!req_tready);
      tracker.note_item(mode, ch, slot, cpos);
      sent_items++;
   endtask

   // slot and position are don't-care on a typed item, so they carry noise
   task automatic type_char(logic [CHAR_W-1:0] ch);
      send_item(MODE_TYPE, ch, SLOT_W'($urandom_range(0, 15)), CPOS_W'($urandom_range(0, 63)));
   endtask

   task automatic load_byte(int slot, int cpos, logic [CHAR_W-1:0] ch);
      send_item(MODE_LOAD, ch, SLOT_W'(slot), CPOS_W'(cpos));
   endtask

   // small alphabet so that words share prefixes, some zeros to end words
   function automatic logic [CHAR_W-1:0] pick_load_byte();
      int r;
      r = $urandom_range(0, 19);
      if (r < 12) return CHAR_W'(8'h61 + $urandom_range(0, 3));
      else if (r < 15) return 8'h00;
      else return CHAR_W'($urandom_range(0, 255));
   endfunction

   // mostly follow one of the live words, otherwise zero or noise
   function automatic logic [CHAR_W-1:0] next_char();
      int live_q [$];
      int r;
      r = $urandom_range(0, 19);
      for (int w = 0; w < WORDS_DEF; w++) if (tracker.live_words[w]) live_q.push_back(w);
      if (r < 15 && live_q.size() != 0 && tracker.type_pos < WORD_LEN_DEF)
         return tracker.dict_bytes[live_q[$urandom_range(0, live_q.size() - 1)]][tracker.type_pos];
      else if (r < 17) return 8'h00;
      else return CHAR_W'($urandom_range(0, 255));
   endfunction

   // result side: random stalls, check every accepted item
   initial begin : result_side
      int stall;
      stall = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            tracker.check_match(rsp_tdata[INDEX_W-1:0], rsp_tlast);
         if (stall > 0) stall--;
         else if (idle_on && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 14);
         rsp_tready <= (stall == 0);
      end
   end

   // run limit, covers the dictionary clear after reset as well
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      int episodes;
      int run_len;
      int src;
      int dst;
      int k;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = MODE_TYPE;
      tracker = new();
      idle_on = 1'b1;
      sent_items = 0;
      episodes = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty dictionary: zero matches every word, twice
      type_char(8'h00);
      type_char(8'h00);
      // no match, position still advances
      type_char(8'hFF);
      type_char(8'h00);
      type_char(RESET_CHAR);
      // extremes of slot, position and byte
      load_byte(0, 0, 8'hFF);
      load_byte(0, 1, 8'h01);
      load_byte(15, 0, 8'hFF);
      load_byte(15, 1, 8'h80);
      load_byte(7, 0, RESET_CHAR);
      load_byte(15, 63, 8'hAA);
      type_char(8'hFF);
      type_char(8'h80);
      type_char(8'h00);
      type_char(RESET_CHAR);
      type_char(8'h00);
      // restart in mid-prefix
      type_char(RESET_CHAR);
      type_char(8'h7F);
      type_char(RESET_CHAR);

      // episodes: a few loads, usually a restart, then a typed run
      while (sent_items < TOTAL_ITEMS) begin
         idle_on = (sent_items < TOTAL_ITEMS * 4 / 5);
         if ($urandom_range(0, 1) == 0) begin
            // clone a prefix into another word, then make it diverge
            src = $urandom_range(0, 15);
            dst = $urandom_range(0, 15);
            k = $urandom_range(1, 6);
            for (int i = 0; i < k; i++) load_byte(dst, i, tracker.dict_bytes[src][i]);
            load_byte(dst, $urandom_range(0, k), pick_load_byte());
         end
         repeat ($urandom_range(0, 8)) begin
            if ($urandom_range(0, 9) < 7) load_byte($urandom_range(0, 15), $urandom_range(0, 7),
                                                    pick_load_byte());
            else load_byte($urandom_range(0, 15), $urandom_range(0, 63), pick_load_byte());
         end
         // two long runs walk past the end of the words
         if (episodes == 0 || episodes == 15) begin
            run_len = $urandom_range(64, 70);
            type_char(RESET_CHAR);
         end else begin
            run_len = $urandom_range(1, 8);
            if ($urandom_range(0, 9) < 7) type_char(RESET_CHAR);
         end
         repeat (run_len) type_char(next_char());
         episodes++;
      end
      req_tvalid <= 1'b0;

      while (tracker.pending_matches.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.failures == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/ips_pkg.sv
rtl/incremental_prefix_search.sv
tb/incremental_prefix_search_tb.sv
